/* rtl/crs_pkg.sv */
// Package for the circle row span block: payload types, lane type and sizes.
package crs_pkg;

   // Widths of the square root datapath
   localparam int ROOT_W     = 15;
   localparam int REM_W      = 31;
   localparam int CELL_COUNT = ROOT_W;

   typedef enum logic [1:0] {
      ST_VALID   = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_INVALID = 2'd2
   } crs_status_type;

   typedef struct packed {
      logic signed [15:0] ctr_x;
      logic signed [15:0] ctr_y;
      logic signed [15:0] radius;
      logic signed [15:0] row_offset;
   } crs_req_type;

   typedef struct packed {
      crs_status_type     status;
      logic [14:0]        half_width;
      logic signed [15:0] left_x;
      logic signed [15:0] right_x;
      logic signed [15:0] row_y;
   } crs_rsp_type;

   // What travels down the root cell chain with each request
   typedef struct packed {
      crs_status_type     status;
      logic [15:0]        ctr_x;
      logic [15:0]        row_y;
      logic [REM_W-1:0]   rem;
      logic [ROOT_W-1:0]  root;
   } crs_lane_type;

endpackage

/* rtl/crs_front.sv */
// Front stages: request register, squares, and row classification.
module crs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  crs_pkg::crs_req_type in_req,
   output logic                in_ready,
   output logic                out_valid,
   output crs_pkg::crs_lane_type out_lane,
   input  logic                out_ready
);
   import crs_pkg::*;

   // Stage one: request register
   logic        s1_valid_ff, s1_valid_in;
   crs_req_type s1_req_ff;
   logic        s1_ready;

   // Stage two: squares and flags
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_ready;
   logic        s2_invalid_ff, s2_invalid_in;
   logic [29:0] s2_r_sq_ff, s2_r_sq_in;
   logic [30:0] s2_off_sq_ff, s2_off_sq_in;
   logic [15:0] s2_cx_ff, s2_row_y_ff, s2_row_y_in;

   logic [15:0] off_mag;
   logic [30:0] off_prod;
   logic [29:0] diff;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   // Magnitudes and squares from the registered request
   always_comb begin
      off_mag       = s1_req_ff.row_offset[15] ? (~s1_req_ff.row_offset + 16'd1)
                                               : s1_req_ff.row_offset;
      off_prod      = {15'd0, off_mag} * {15'd0, off_mag};
      s2_off_sq_in  = off_prod;
      s2_r_sq_in    = {15'd0, s1_req_ff.radius[14:0]} * {15'd0, s1_req_ff.radius[14:0]};
      s2_invalid_in = s1_req_ff.radius[15] || (s1_req_ff.radius == 16'sd0);
      s2_row_y_in   = s1_req_ff.ctr_y + s1_req_ff.row_offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_req_ff <= in_req;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_invalid_ff <= s2_invalid_in;
         s2_r_sq_ff    <= s2_r_sq_in;
         s2_off_sq_ff  <= s2_off_sq_in;
         s2_cx_ff      <= s1_req_ff.ctr_x;
         s2_row_y_ff   <= s2_row_y_in;
      end
   end

   // Classify the row; a row inside the circle starts the root with its remainder
   always_comb begin
      diff              = s2_r_sq_ff - s2_off_sq_ff[29:0];
      out_valid         = s2_valid_ff;
      out_lane.ctr_x    = s2_cx_ff;
      out_lane.row_y    = s2_row_y_ff;
      out_lane.root     = '0;
      out_lane.rem      = '0;
      priority if (s2_invalid_ff) begin
         out_lane.status = ST_INVALID;
      end else if (s2_off_sq_ff > {1'b0, s2_r_sq_ff}) begin
         out_lane.status = ST_EMPTY;
      end else begin
         out_lane.status = ST_VALID;
         out_lane.rem    = {1'b0, diff};
      end
   end

endmodule

/* rtl/crs_cell.sv */
// Square root cell: settles one root bit and passes the request on.
module crs_cell #(
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  crs_pkg::crs_lane_type in_lane,
   output logic                 in_ready,
   output logic                 out_valid,
   output crs_pkg::crs_lane_type out_lane,
   input  logic                 out_ready
);
   import crs_pkg::*;

   logic         valid_ff, valid_in;
   crs_lane_type lane_ff, lane_in;
   logic [REM_W-1:0] trial;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Try setting this bit: (2*root + 2^BIT) * 2^BIT against the remainder
   always_comb begin
      trial   = (REM_W'(in_lane.root) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
      lane_in = in_lane;
      if (in_lane.rem >= trial) begin
         lane_in.rem  = in_lane.rem - trial;
         lane_in.root = in_lane.root | (ROOT_W'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

/* rtl/crs_back.sv */
// Back stage: span edges, final status and the response register.
module crs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  crs_pkg::crs_lane_type in_lane,
   output logic                 in_ready,
   output logic                 out_valid,
   output crs_pkg::crs_rsp_type  out_rsp,
   input  logic                 out_stall
);
   import crs_pkg::*;

   logic        valid_ff, valid_in;
   crs_rsp_type rsp_ff, rsp_in;
   logic [15:0] hw_ext;

   assign in_ready = !valid_ff || !out_stall;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // A zero root inside the circle is an empty row too
   always_comb begin
      hw_ext = {1'b0, in_lane.root};
      rsp_in = '0;
      if (in_lane.status == ST_VALID) begin
         if (in_lane.root == '0) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            rsp_in.status     = ST_VALID;
            rsp_in.half_width = in_lane.root;
            rsp_in.left_x     = in_lane.ctr_x - hw_ext;
            rsp_in.right_x    = in_lane.ctr_x + hw_ext;
            rsp_in.row_y      = in_lane.row_y;
         end
      end else begin
         rsp_in.status = in_lane.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

/* rtl/circle_row_span.sv */
// Top level of the circle row span block: front stages, root cell chain, response stage.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_data   (crs_req_type)
//   rsp       out         rsp_valid / rsp_stall  rsp_data   (crs_rsp_type)
//
// One request per cycle sustained while rsp_stall is low; each response passes through
// two front stages, fifteen root cells (one root bit each) and the response register.
// Every stage holds one request with its own valid bit and fills bubbles ahead of a stall.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// A stalled response holds while earlier stages keep accepting until they are full.
module circle_row_span (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  crs_pkg::crs_req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output crs_pkg::crs_rsp_type  rsp_data
);
   import crs_pkg::*;

   logic         chain_valid [CELL_COUNT+1];
   logic         chain_ready [CELL_COUNT+1];
   crs_lane_type chain_lane  [CELL_COUNT+1];
   logic         front_ready;

   assign req_stall = !front_ready;

   crs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .in_ready  (front_ready),
      .out_valid (chain_valid[0]),
      .out_lane  (chain_lane[0]),
      .out_ready (chain_ready[0])
   );

   // Root cells, most significant bit first
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      crs_cell #(
         .BIT (CELL_COUNT - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_lane   (chain_lane[i]),
         .in_ready  (chain_ready[i]),
         .out_valid (chain_valid[i+1]),
         .out_lane  (chain_lane[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   crs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CELL_COUNT]),
      .in_lane   (chain_lane[CELL_COUNT]),
      .in_ready  (chain_ready[CELL_COUNT]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule

/* tb/sv/crs_checker.sv */
// Checker for circle_row_span: predicts each span from its request and compares responses.
module crs_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  crs_pkg::crs_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  crs_pkg::crs_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import crs_pkg::*;

   crs_rsp_type span_q[$];
   int          mismatch_total = 0;
   int          span_backlog   = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = span_backlog;

   // Expected span for one request: floor root of r^2 - off^2, wrapped coordinates
   function automatic crs_rsp_type predict_span(input crs_req_type q);
      crs_rsp_type s;
      logic [31:0] rad_sq;
      logic [31:0] off_sq;
      logic [31:0] diff;
      logic [15:0] off_mag;
      logic [15:0] root;
      logic [15:0] trial;
      s = '0;
      s.status = ST_VALID;
      if (q.radius <= 0) begin
         s.status = ST_INVALID;
         return s;
      end
      rad_sq  = {16'd0, q.radius} * {16'd0, q.radius};
      // magnitude of -32768 is 0x8000, still exact in 16 unsigned bits
      off_mag = q.row_offset[15] ? (16'd0 - q.row_offset) : q.row_offset;
      off_sq  = {16'd0, off_mag} * {16'd0, off_mag};
      if (off_sq > rad_sq) begin
         s.status = ST_EMPTY;
         return s;
      end
      diff = rad_sq - off_sq;
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (16'd1 << b);
         if ({16'd0, trial} * {16'd0, trial} <= diff) begin
            root = trial;
         end
      end
      // a single-point row counts as empty
      if (root == 16'd0) begin
         s.status = ST_EMPTY;
         return s;
      end
      s.half_width = root[14:0];
      s.left_x     = q.ctr_x - root;
      s.right_x    = q.ctr_x + root;
      s.row_y      = q.ctr_y + q.row_offset;
      return s;
   endfunction

   task automatic flag_field(input string fname, input logic signed [16:0] exp_v,
                             input logic signed [16:0] act_v);
      $error("%s mismatch: expected %0d, got %0d", fname, exp_v, act_v);
      mismatch_total++;
   endtask

   // Sample both channels at the edge; responses drain before new requests queue
   always @(posedge clock) begin
      crs_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (span_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_total++;
            end else begin
               want = span_q.pop_front();
               if (rsp_data.status !== want.status)
                  flag_field("status", want.status, rsp_data.status);
               if (rsp_data.half_width !== want.half_width)
                  flag_field("half_width", want.half_width, rsp_data.half_width);
               if (rsp_data.left_x !== want.left_x)
                  flag_field("left_x", want.left_x, rsp_data.left_x);
               if (rsp_data.right_x !== want.right_x)
                  flag_field("right_x", want.right_x, rsp_data.right_x);
               if (rsp_data.row_y !== want.row_y)
                  flag_field("row_y", want.row_y, rsp_data.row_y);
            end
         end
         if (req_valid && !req_stall) begin
            span_q.push_back(predict_span(req_data));
         end
      end
      span_backlog <= span_q.size();
   end

endmodule

/* tb/sv/tb_circle_row_span.sv */
// Testbench top for circle_row_span: clock, reset, request stimulus, response stalls, verdict.
module tb_circle_row_span;
   timeunit 1ns;
   timeprecision 1ps;
   import crs_pkg::*;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   crs_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   crs_rsp_type rsp_data;
   int          fail_count;
   int          pending_count;
   int          sent      = 0;
   bit          quiet     = 1'b0;

   circle_row_span u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   crs_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop if the pipeline hangs
   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic crs_req_type make_req(input logic signed [15:0] cx,
                                            input logic signed [15:0] cy,
                                            input logic signed [15:0] rad,
                                            input logic signed [15:0] off);
      crs_req_type q;
      q.ctr_x      = cx;
      q.ctr_y      = cy;
      q.radius     = rad;
      q.row_offset = off;
      return q;
   endfunction

   // Called at a rising edge; returns at the edge after acceptance and any idle gap
   task automatic push_request(input crs_req_type d);
      int gap;
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side stalls: short bursts, occasional long free-running stretches
   initial begin
      int go_len;
      int hold_len;
      forever begin
         go_len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (go_len) @(posedge clock);
         hold_len = pick_gap();
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
         end
      end
   end

   // Request stimulus and verdict
   initial begin
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      int rad;
      int lo;
      int hi;
      int off;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // invalid radii
      push_request(make_req(16'sd10, 16'sd20, 16'sd0, 16'sd0));
      push_request(make_req(-16'sd1, -16'sd1, -16'sd1, -16'sd1));
      push_request(make_req(16'sd0, 16'sd0, -16'sd32768, 16'sd5));
      // unit circle: center row, then the zero-width edges
      push_request(make_req(16'sd100, 16'sd200, 16'sd1, 16'sd0));
      push_request(make_req(16'sd100, 16'sd200, 16'sd1, 16'sd1));
      push_request(make_req(16'sd100, 16'sd200, 16'sd1, -16'sd1));
      // small circle rows and one outside
      push_request(make_req(-16'sd50, 16'sd7, 16'sd5, 16'sd3));
      push_request(make_req(-16'sd50, 16'sd7, 16'sd5, -16'sd4));
      push_request(make_req(-16'sd50, 16'sd7, 16'sd5, 16'sd6));
      // largest radius with x wrapping both ways
      push_request(make_req(16'sd32767, 16'sd0, 16'sd32767, 16'sd0));
      push_request(make_req(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0));
      push_request(make_req(16'sd0, 16'sd0, 16'sd32767, 16'sd1));
      push_request(make_req(16'sd0, 16'sd0, 16'sd32767, 16'sd181));
      push_request(make_req(16'sd0, 16'sd0, 16'sd32767, 16'sd32767));
      push_request(make_req(16'sd0, 16'sd0, 16'sd32767, -16'sd32767));
      // most negative offset lies outside every circle
      push_request(make_req(16'sd0, 16'sd0, 16'sd32767, -16'sd32768));
      push_request(make_req(16'sd0, 16'sd0, 16'sd1, -16'sd32768));
      // row y wrap
      push_request(make_req(16'sd3, 16'sd32767, 16'sd32767, 16'sd20000));
      push_request(make_req(16'sd3, -16'sd32768, 16'sd40, -16'sd1));
      push_request(make_req(-16'sd1, -16'sd1, 16'sd32767, -16'sd12345));

      // random part: mostly full row sweeps of random circles, some raw noise
      while (sent < 1750) begin
         quiet = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 3) == 0) begin
            push_request({$urandom(), $urandom()});
         end else begin
            cx = 16'($urandom());
            cy = 16'($urandom());
            case ($urandom_range(0, 19))
               0:       rad = $urandom_range(2001, 32767);
               1, 2, 3: rad = $urandom_range(41, 2000);
               default: rad = $urandom_range(1, 40);
            endcase
            lo = -rad;
            hi = rad;
            // sometimes one row past each edge
            if ($urandom_range(0, 3) == 0) begin
               lo--;
               hi++;
            end
            if (rad <= 40) begin
               for (off = lo; off <= hi; off++) begin
                  push_request(make_req(cx, cy, 16'(rad), 16'(off)));
               end
            end else begin
               push_request(make_req(cx, cy, 16'(rad), 16'(lo)));
               repeat (10) begin
                  off = $urandom_range(0, hi - lo) + lo;
                  push_request(make_req(cx, cy, 16'(rad), 16'(off)));
               end
               push_request(make_req(cx, cy, 16'(rad), 16'(hi)));
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      // drain, then allow for any stray response
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/crs_pkg.sv
rtl/crs_front.sv
rtl/crs_cell.sv
rtl/crs_back.sv
rtl/circle_row_span.sv
tb/sv/crs_checker.sv
tb/sv/tb_circle_row_span.sv
